// ----- design/word_to_decimal_digits_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the word to decimal digits unit
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef WORD_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH
`define WORD_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication
`define W2DD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define W2DD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/w2dd_pkg.sv -----
// ----------------------------------------------------------------------------
// w2dd_pkg
// Types and constants shared by the word to decimal digits unit.
// ----------------------------------------------------------------------------
package w2dd_pkg;

	// Longest integer result: 2^64-1 has twenty decimal digits
	localparam int MAX_DIGITS = 20;
	localparam int BCD_W      = MAX_DIGITS * 4;
	localparam int LIM_W      = 5;
	localparam int CHAR_W     = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Bits shifted into the BCD register per converter cycle
	localparam int BITS_PER_STEP = 4;

	// Output modes, carried on the input tuser
	typedef enum logic [1:0] {
		KIND_MIN_INT   = 2'd0,
		KIND_PAD_INT   = 2'd1,
		KIND_FULL_FRAC = 2'd2,
		KIND_LIM_FRAC  = 2'd3
	} w2dd_kind_t;

	// Converter sequencer states
	typedef enum logic [1:0] {
		CV_IDLE,
		CV_RUN,
		CV_DONE
	} w2dd_cv_state_t;

	// Classified job, as decided by the front part
	typedef struct packed {
		w2dd_kind_t       kind;
		logic [LIM_W-1:0] lim;   // clamped to the group size
		logic             err;   // value out of range, one error item
	} w2dd_job_t;

	// Converted job handed from converter to digit sequencer
	typedef struct packed {
		w2dd_job_t        job;
		logic [BCD_W-1:0] bcd;   // twenty BCD digits, least significant lowest
	} w2dd_conv_t;

	// 10^n, evaluated at elaboration
	function automatic logic [63:0] pow_ten(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

// ----- design/word_to_decimal_digits_unit.sv -----
// ----------------------------------------------------------------------------
// word_to_decimal_digits_unit
// Converts a binary word into ASCII decimal digits, one output item per digit.
// ----------------------------------------------------------------------------
// Each accepted word goes through a binary to BCD converter that shifts in
// four bits per cycle; the digit sequencer then sends one digit per cycle
// while the output is not stalled, up to 20. The converter works on the next
// word while the sequencer sends the current one. Words that give no digits
// (zero in minimal integer mode; zero value, or zero limit with an in-range
// value, in limited fraction mode) are dropped at the input. A value of
// 10^DIGITS_PER_WORD or more in modes 1 to 3 gives one item with tuser set.
// ----------------------------------------------------------------------------
module word_to_decimal_digits_unit #(
	parameter int WORD_BITS       = 64,
	parameter int DIGITS_PER_WORD = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,    // value[63:0], digit_limit[68:64], zero fill
	input  logic [1:0]  s_tuser,    // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // digit_char[5:0], zero fill
	output logic        m_tlast,    // is_last
	output logic [0:0]  m_tuser     // range_error[0]
);

	localparam int JOB_W   = $bits(w2dd_pkg::w2dd_job_t);
	localparam int Q_W     = WORD_BITS + JOB_W;
	localparam int Q_DEPTH = 2;

	logic                          q_full;
	logic                          q_push;
	logic [WORD_BITS-1:0]          f_value;
	w2dd_pkg::w2dd_job_t           f_job;
	logic                          q_valid;
	logic                          q_pop;
	logic [Q_W-1:0]                q_rdata;
	logic                          c_valid;
	logic                          c_ready;
	w2dd_pkg::w2dd_conv_t          c_data;
	logic [w2dd_pkg::CHAR_W-1:0]   out_char;
	logic                          out_err;

	// Front: accept and classify
	w2dd_front #(
		.WORD_BITS       (WORD_BITS),
		.DIGITS_PER_WORD (DIGITS_PER_WORD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_value  (f_value),
		.q_job    (f_job)
	);

	// Job queue
	w2dd_fifo #(
		.W     (Q_W),
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_value, f_job}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	// Back: conversion
	w2dd_conv #(
		.WORD_BITS (WORD_BITS)
	) u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_value (q_rdata[Q_W-1:JOB_W]),
		.q_job   (w2dd_pkg::w2dd_job_t'(q_rdata[JOB_W-1:0])),
		.c_valid (c_valid),
		.c_ready (c_ready),
		.c_data  (c_data)
	);

	// Back: digit sequencing
	w2dd_emit #(
		.DIGITS_PER_WORD (DIGITS_PER_WORD)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.c_valid  (c_valid),
		.c_ready  (c_ready),
		.c_data   (c_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_char (out_char),
		.out_last (m_tlast),
		.out_err  (out_err)
	);

	assign m_tdata = {2'b00, out_char};
	assign m_tuser = out_err;

endmodule

// ----- design/w2dd_front.sv -----
// ----------------------------------------------------------------------------
// w2dd_front
// Accepts input items, range-checks and clamps them, drops items that give
// no result and pushes the rest as jobs into the queue.
// ----------------------------------------------------------------------------
module w2dd_front #(
	parameter int WORD_BITS       = 64,
	parameter int DIGITS_PER_WORD = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [71:0]                s_tdata,   // value[63:0], digit_limit[68:64]
	input  logic [1:0]                 s_tuser,   // kind[1:0]
	input  logic                       q_full,
	output logic                       q_push,
	output logic [WORD_BITS-1:0]       q_value,
	output w2dd_pkg::w2dd_job_t        q_job
);

	localparam logic [63:0] GROUP_BASE = w2dd_pkg::pow_ten(DIGITS_PER_WORD);
	localparam logic [w2dd_pkg::LIM_W-1:0] GROUP_DIGITS =
		w2dd_pkg::LIM_W'(DIGITS_PER_WORD);

	w2dd_pkg::w2dd_kind_t            kind;
	logic [WORD_BITS-1:0]            value;
	logic [w2dd_pkg::LIM_W-1:0]      lim_raw;
	logic [w2dd_pkg::LIM_W-1:0]      lim;
	logic                            err;
	logic                            is_zero;
	logic                            drop;
	logic                            accept;

	// Unpack the item
	assign kind    = w2dd_pkg::w2dd_kind_t'(s_tuser);
	assign value   = s_tdata[WORD_BITS-1:0];
	assign lim_raw = s_tdata[68:64];
	assign is_zero = (value == '0);

	// Classification
	always_comb begin
		err  = (kind != w2dd_pkg::KIND_MIN_INT) && (64'(value) >= GROUP_BASE);
		lim  = (lim_raw > GROUP_DIGITS) ? GROUP_DIGITS : lim_raw;
		drop = 1'b0;
		case (kind)
			w2dd_pkg::KIND_MIN_INT:  drop = is_zero;
			w2dd_pkg::KIND_LIM_FRAC: drop = !err && (is_zero || (lim == '0));
			default:                 drop = 1'b0;
		endcase
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && !drop;
	assign q_value  = value;
	assign q_job    = '{kind: kind, lim: lim, err: err};

	`include "word_to_decimal_digits_unit_assert.svh"

	`W2DD_ASSERT_NOW(a_front_no_push_full, q_push, !q_full, "push into a full queue")

endmodule

// ----- design/w2dd_fifo.sv -----
// ----------------------------------------------------------------------------
// w2dd_fifo
// Short job queue between the front and back parts, in flip-flops.
// DEPTH must be a power of two, two or more.
// ----------------------------------------------------------------------------
module w2dd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         valid
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;
	logic          do_pop;

	assign full   = (count_q == (AW+1)'(DEPTH));
	assign valid  = (count_q != '0);
	assign rdata  = mem_q[rptr_q];
	assign do_pop = pop && valid;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	`include "word_to_decimal_digits_unit_assert.svh"

	`W2DD_ASSERT_NOW(a_fifo_level, 1'b1, count_q <= (AW+1)'(DEPTH), "queue level above depth")

endmodule

// ----- design/w2dd_conv.sv -----
// ----------------------------------------------------------------------------
// w2dd_conv
// Binary to BCD converter: shift-and-add-three, four bits per cycle.
// Out-of-range jobs skip the conversion.
// ----------------------------------------------------------------------------
module w2dd_conv #(
	parameter int WORD_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  logic [WORD_BITS-1:0]  q_value,
	input  w2dd_pkg::w2dd_job_t   q_job,
	output logic                  c_valid,
	input  logic                  c_ready,
	output w2dd_pkg::w2dd_conv_t  c_data
);

	localparam int BPS    = w2dd_pkg::BITS_PER_STEP;
	localparam int STEPS  = (WORD_BITS + BPS - 1) / BPS;
	localparam int SH_W   = STEPS * BPS;
	localparam int STEP_W = $clog2(STEPS);
	localparam int BCD_W  = w2dd_pkg::BCD_W;

	w2dd_pkg::w2dd_cv_state_t state_q;
	w2dd_pkg::w2dd_cv_state_t state_d;
	w2dd_pkg::w2dd_job_t      job_q;
	logic [SH_W-1:0]          sh_q;
	logic [BCD_W-1:0]         bcd_q;
	logic [STEP_W-1:0]        cnt_q;
	logic [SH_W-1:0]          sh_d;
	logic [BCD_W-1:0]         bcd_d;
	logic                     load;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			w2dd_pkg::CV_IDLE: begin
				if (q_valid) begin
					state_d = q_job.err ? w2dd_pkg::CV_DONE : w2dd_pkg::CV_RUN;
				end
			end
			w2dd_pkg::CV_RUN: begin
				if (cnt_q == '0) begin
					state_d = w2dd_pkg::CV_DONE;
				end
			end
			w2dd_pkg::CV_DONE: begin
				if (c_ready) begin
					state_d = w2dd_pkg::CV_IDLE;
				end
			end
			default: state_d = w2dd_pkg::CV_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		q_pop   = 1'b0;
		c_valid = 1'b0;
		case (state_q)
			w2dd_pkg::CV_IDLE: q_pop   = q_valid;
			w2dd_pkg::CV_DONE: c_valid = 1'b1;
			default: begin
				q_pop   = 1'b0;
				c_valid = 1'b0;
			end
		endcase
	end

	assign load   = q_pop;
	assign c_data = '{job: job_q, bcd: bcd_q};

	// Four dabble steps: add three to digits of five or more, then shift in
	always_comb begin
		logic [BCD_W-1:0] b;
		logic [SH_W-1:0]  s;
		b = bcd_q;
		s = sh_q;
		for (int k = 0; k < BPS; k++) begin
			for (int j = 0; j < w2dd_pkg::MAX_DIGITS; j++) begin
				if (b[j*4 +: 4] >= 4'd5) begin
					b[j*4 +: 4] = b[j*4 +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], s[SH_W-1]};
			s = {s[SH_W-2:0], 1'b0};
		end
		bcd_d = b;
		sh_d  = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= w2dd_pkg::CV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
			sh_q  <= SH_W'(q_value);
			bcd_q <= '0;
			cnt_q <= STEP_W'(STEPS - 1);
		end else if (state_q == w2dd_pkg::CV_RUN) begin
			sh_q  <= sh_d;
			bcd_q <= bcd_d;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	`include "word_to_decimal_digits_unit_assert.svh"

	`W2DD_ASSERT_NOW(a_conv_run_no_err, state_q == w2dd_pkg::CV_RUN, !job_q.err, "error job converted")

endmodule

// ----- design/w2dd_emit.sv -----
// ----------------------------------------------------------------------------
// w2dd_emit
// Digit sequencer: walks the BCD digits in the order the mode asks for and
// sends one ASCII digit per cycle, while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module w2dd_emit #(
	parameter int DIGITS_PER_WORD = 19
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              c_valid,
	output logic                              c_ready,
	input  w2dd_pkg::w2dd_conv_t              c_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [w2dd_pkg::CHAR_W-1:0]       out_char,
	output logic                              out_last,
	output logic                              out_err
);

	localparam int BCD_W = w2dd_pkg::BCD_W;
	localparam int TOP   = DIGITS_PER_WORD * 4 - 1;
	localparam int LOW_W = (DIGITS_PER_WORD - 1) * 4;

	logic                        busy_q;
	w2dd_pkg::w2dd_kind_t        kind_q;
	logic                        err_q;
	logic [w2dd_pkg::LIM_W-1:0]  cnt_q;
	logic [BCD_W-1:0]            dig_q;
	logic                        out_valid_q;
	logic [w2dd_pkg::CHAR_W-1:0] out_char_q;
	logic                        out_last_q;
	logic                        out_err_q;
	logic                        step;
	logic                        last;
	logic                        lsb_first;
	logic [3:0]                  cur;
	logic [w2dd_pkg::CHAR_W-1:0] cur_char;

	assign step      = busy_q && (!out_valid_q || m_tready);
	assign lsb_first = kind_q inside {w2dd_pkg::KIND_MIN_INT, w2dd_pkg::KIND_PAD_INT};
	assign cur       = lsb_first ? dig_q[3:0] : dig_q[TOP -: 4];
	assign cur_char  = err_q ? '0 : (w2dd_pkg::ASCII_ZERO | w2dd_pkg::CHAR_W'(cur));

	// End of the job
	always_comb begin
		if (err_q) begin
			last = 1'b1;
		end else begin
			case (kind_q)
				w2dd_pkg::KIND_MIN_INT:  last = (dig_q[BCD_W-1:4] == '0);
				w2dd_pkg::KIND_LIM_FRAC: last = (cnt_q == 5'd1) || (dig_q[LOW_W-1:0] == '0);
				default:                 last = (cnt_q == 5'd1);
			endcase
		end
	end

	assign c_ready = !busy_q || (step && last);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (c_valid && c_ready) begin
				busy_q <= 1'b1;
			end else if (step && last) begin
				busy_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit register and output register; minimal integers may run to twenty digits
	always_ff @(posedge clk) begin
		if (c_valid && c_ready) begin
			kind_q <= c_data.job.kind;
			err_q  <= c_data.job.err;
			dig_q  <= c_data.bcd;
			if ((c_data.job.kind == w2dd_pkg::KIND_LIM_FRAC) && !c_data.job.err) begin
				cnt_q <= c_data.job.lim;
			end else if (c_data.job.kind == w2dd_pkg::KIND_MIN_INT) begin
				cnt_q <= w2dd_pkg::LIM_W'(w2dd_pkg::MAX_DIGITS);
			end else begin
				cnt_q <= w2dd_pkg::LIM_W'(DIGITS_PER_WORD);
			end
		end else if (step) begin
			dig_q <= lsb_first ? (dig_q >> 4) : (dig_q << 4);
			cnt_q <= cnt_q - 1'b1;
		end
		if (step) begin
			out_char_q <= cur_char;
			out_last_q <= last;
			out_err_q  <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign out_char = out_char_q;
	assign out_last = out_last_q;
	assign out_err  = out_err_q;

	`include "word_to_decimal_digits_unit_assert.svh"

	`W2DD_ASSERT_NOW(a_emit_cnt_live, busy_q, cnt_q != '0, "digit count ran out while busy")
	`W2DD_ASSERT_NOW(a_emit_err_item, out_valid_q && out_err_q, (out_char_q == '0) && out_last_q, "error item malformed")
	`W2DD_ASSERT_NEXT(a_emit_hold, out_valid_q && !m_tready, out_valid_q, "stalled item dropped")

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the word to decimal digits unit. Words go in on the
// slave side in all four modes, in a directed set and then at random. Every
// digit expected from each accepted word is queued by a predictor in this
// file, and each digit leaving the master side is checked against the
// oldest one, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import w2dd_pkg::*;

	localparam int          DIGITS_PER_WORD = 19;
	localparam logic [63:0] TEN_POW_18      = 64'd1000000000000000000;
	localparam logic [63:0] TEN_POW_19      = 64'd10000000000000000000;
	localparam logic [63:0] ALL_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          IDLE_PCT        = 29;
	localparam int          TAIL_CYCLES     = 80;
	localparam int          REPORT_MAX      = 10;

	// One expected digit item
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              err;
	} digit_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;    // value[63:0], digit_limit[68:64], zero fill
	w2dd_kind_t  s_tuser  = KIND_MIN_INT;    // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;    // digit_char[5:0], zero fill
	logic        m_tlast;
	logic [0:0]  m_tuser;    // range_error[0]

	digit_item_t digits_due[$];
	int          mismatches = 0;
	bit          no_idle    = 1'b0;

	word_to_decimal_digits_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Digits expected from one word, queued in output order
	function automatic void predict_digits(input w2dd_kind_t kind, input logic [63:0] value,
		input logic [4:0] lim);
		logic [63:0] v;
		logic [3:0]  dig [MAX_DIGITS];
		logic [3:0]  pad [DIGITS_PER_WORD];
		int          n;
		int          sig;
		int          lim_c;
		digit_item_t it;
		v     = value;
		n     = 0;
		lim_c = (lim > DIGITS_PER_WORD) ? DIGITS_PER_WORD : int'(lim);
		if (kind == KIND_MIN_INT) begin
			while (v != 0 && n < MAX_DIGITS) begin
				dig[n] = 4'(v % 64'd10);
				v      = v / 64'd10;
				n++;
			end
		end else if (v >= TEN_POW_19) begin
			// out of range: a single error item
			it.ch   = '0;
			it.last = 1'b1;
			it.err  = 1'b1;
			digits_due.push_back(it);
			return;
		end else begin
			// padded group, least significant digit in pad[0]
			for (int i = 0; i < DIGITS_PER_WORD; i++) begin
				pad[i] = 4'(v % 64'd10);
				v      = v / 64'd10;
			end
			if (kind == KIND_PAD_INT) begin
				for (int i = 0; i < DIGITS_PER_WORD; i++) dig[i] = pad[i];
				n = DIGITS_PER_WORD;
			end else if (kind == KIND_FULL_FRAC) begin
				for (int i = 0; i < DIGITS_PER_WORD; i++) dig[i] = pad[DIGITS_PER_WORD-1-i];
				n = DIGITS_PER_WORD;
			end else begin
				// drop trailing zeros, then apply the limit
				sig = DIGITS_PER_WORD;
				while (sig > 0 && pad[DIGITS_PER_WORD-sig] == 4'd0) sig--;
				n = (sig < lim_c) ? sig : lim_c;
				for (int i = 0; i < n; i++) dig[i] = pad[DIGITS_PER_WORD-1-i];
			end
		end
		for (int i = 0; i < n; i++) begin
			it.ch   = ASCII_ZERO + {2'b00, dig[i]};
			it.last = (i == n - 1);
			it.err  = 1'b0;
			digits_due.push_back(it);
		end
	endfunction

	// Random word, spread over the interesting value classes
	function automatic logic [63:0] rand_value();
		logic [63:0] r;
		logic [63:0] p;
		int          k;
		r = {$urandom(), $urandom()};
		case ($urandom_range(5, 0))
			0: begin
				return r;
			end
			1, 5: begin
				return r % TEN_POW_19;
			end
			2: begin
				return r >> $urandom_range(63, 0);
			end
			3: begin
				// trailing zeros, still in range
				k = $urandom_range(18, 1);
				p = 64'd1;
				for (int i = 0; i < k; i++) p = p * 64'd10;
				return (r % (TEN_POW_19 / p)) * p;
			end
			default: begin
				return TEN_POW_19 - 64'd3 + 64'($urandom_range(5, 0));
			end
		endcase
	endfunction

	// Offer one word, hold it until accepted, then queue its digits
	task automatic send_word(input w2dd_kind_t kind, input logic [63:0] value,
		input logic [4:0] lim);
		if (!no_idle) begin
			while ($urandom_range(99, 0) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, lim, value};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		predict_digits(kind, value, lim);
	endtask

	task automatic send_random_word();
		send_word(w2dd_kind_t'($urandom_range(3, 0)), rand_value(), 5'($urandom_range(31, 0)));
	endtask

	// Stop offering and wait for every queued digit
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digits_due.size() != 0) @(posedge clk);
	endtask

	// Boundaries of every mode, the empty cases and the error cases
	task automatic test_directed_cases();
		send_word(KIND_MIN_INT, 64'd0, 5'd0);
		send_word(KIND_MIN_INT, 64'd1, 5'd31);
		send_word(KIND_MIN_INT, 64'd9, 5'd0);
		send_word(KIND_MIN_INT, 64'd10, 5'd7);
		send_word(KIND_MIN_INT, ALL_ONES, 5'd31);
		send_word(KIND_MIN_INT, TEN_POW_19, 5'd19);
		send_word(KIND_MIN_INT, TEN_POW_19 - 64'd1, 5'd0);
		send_word(KIND_PAD_INT, 64'd0, 5'd0);
		send_word(KIND_PAD_INT, TEN_POW_19 - 64'd1, 5'd31);
		send_word(KIND_PAD_INT, TEN_POW_19, 5'd5);
		send_word(KIND_PAD_INT, ALL_ONES, 5'd31);
		send_word(KIND_FULL_FRAC, 64'd0, 5'd0);
		send_word(KIND_FULL_FRAC, 64'd1, 5'd31);
		send_word(KIND_FULL_FRAC, TEN_POW_18, 5'd3);
		send_word(KIND_FULL_FRAC, TEN_POW_19, 5'd19);
		send_word(KIND_LIM_FRAC, 64'd0, 5'd5);
		send_word(KIND_LIM_FRAC, 64'd123456789, 5'd0);
		send_word(KIND_LIM_FRAC, TEN_POW_18, 5'd19);
		send_word(KIND_LIM_FRAC, TEN_POW_19 - 64'd1, 5'd31);
		send_word(KIND_LIM_FRAC, 64'd123, 5'd20);
		send_word(KIND_LIM_FRAC, 64'd1200000000000000000, 5'd3);
		send_word(KIND_LIM_FRAC, 64'd1200000000000000000, 5'd1);
		send_word(KIND_LIM_FRAC, TEN_POW_19, 5'd0);
		send_word(KIND_LIM_FRAC, ALL_ONES, 5'd19);
		send_word(KIND_LIM_FRAC, 64'd5000000000000000000, 5'd25);
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_random_word();
	endtask

	// Both sides flat out, no idling at all
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		repeat (count) send_random_word();
		no_idle = 1'b0;
	endtask

	// Short bursts, each left to drain completely before the next
	task automatic test_pause_until_drained();
		repeat (4) begin
			repeat (10) send_random_word();
			hold_until_drained();
		end
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) $display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// Receiver idling
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
	end

	// Compare each accepted digit item with the oldest expectation
	always @(posedge clk) begin
		digit_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digits_due.size() == 0) begin
				note_mismatch($sformatf("unexpected item char=%0d last=%0b err=%0b",
					m_tdata[5:0], m_tlast, m_tuser[0]));
			end else begin
				want = digits_due.pop_front();
				if (m_tdata[5:0] !== want.ch || m_tlast !== want.last
					|| m_tuser[0] !== want.err) begin
					note_mismatch($sformatf(
						"expected char=%0d last=%0b err=%0b, got char=%0d last=%0b err=%0b",
						want.ch, want.last, want.err, m_tdata[5:0], m_tlast, m_tuser[0]));
				end
			end
		end
	end

	// Run limit
	initial begin
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_mix(330);
		test_back_to_back(80);
		test_pause_until_drained();
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && digits_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/w2dd_pkg.sv
design/w2dd_front.sv
design/w2dd_fifo.sv
design/w2dd_conv.sv
design/w2dd_emit.sv
design/word_to_decimal_digits_unit.sv
test/tb.sv
